@@ sv/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

    // One HSV color on the input channel
    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } hsv_in_t;

    // One RGB color on the result channel
    typedef struct packed {
        logic       accepted;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_out_t;

    // Stage enables for the channel scaler
    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic div_en;
    } hsvrgb_en_t;

    // Rounded channel before the final divide by 15 stays below 3840
    localparam int SCALED_W    = 12;
    // floor(m / 15) == (m * 8739) >> 17 for every m below 3840
    localparam int DIV15_MUL   = 8739;
    localparam int DIV15_SHIFT = 17;
    localparam int DIV15_W     = 14;

endpackage

@@ sv/hsv_to_rgb.sv @@
// HSV to RGB color converter. Each transfer on s_ carries hue (unsigned,
// 2^-HUE_FRACTION_BITS degree), saturation and brightness (unsigned, one is
// 2^LEVEL_FRACTION_BITS). Each yields one transfer on m_ with 8-bit red, green
// and blue, each the exact channel level times 255 rounded half up. A hue
// above 360 degrees or a saturation or brightness above one gives
// accepted = 0 and all channels 0; zero saturation gives gray; hue 360 wraps
// to 0. The six-stage pipeline (decode, products, sector select, level
// multiply, rounding, divide by 15) takes one color every clock while m_ready
// is high; a stalled m_ready backs up through the stages with no loss, so
// s_ready drops only when all six stages are full.
module hsv_to_rgb
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS   = 6,
    parameter int LEVEL_FRACTION_BITS = 15
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hsv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rgb_out_t m_data
);

    localparam int NST = 6;
    localparam int RW  = HUE_FRACTION_BITS + 6;
    localparam int AW  = LEVEL_FRACTION_BITS + HUE_FRACTION_BITS + 6;
    localparam int VW  = LEVEL_FRACTION_BITS + 1;

    localparam int unsigned SECTOR_SPAN = 32'd60 << HUE_FRACTION_BITS;
    localparam int unsigned FULL_TURN   = 32'd360 << HUE_FRACTION_BITS;
    localparam int unsigned LEVEL_ONE   = 32'd1 << LEVEL_FRACTION_BITS;

    localparam logic [RW-1:0] SPAN_R   = RW'(SECTOR_SPAN);
    localparam logic [AW-1:0] SPAN_A   = AW'(SECTOR_SPAN);
    localparam logic [AW-1:0] ONE_A    = AW'(LEVEL_ONE);
    localparam logic [AW-1:0] FULL_AMT = AW'(64'(SECTOR_SPAN) << LEVEL_FRACTION_BITS);

    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;
    localparam logic [2:0] SEC_MAGENTA = 3'd5;

    logic [NST-1:0] stage_en;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ok_reg;

    // Stage 0: range check, hue wrap, sector split
    logic          ok_next;
    logic          gray_next;
    logic [2:0]    sector_next;
    logic [RW-1:0] rem_next;
    logic [31:0]   hue_w;
    logic [31:0]   base;
    logic          gray0_reg;
    logic [2:0]    sector0_reg;
    logic [RW-1:0] rem0_reg;
    logic [15:0]   sat0_reg;
    logic [VW-1:0] level0_reg;

    // Stage 1: saturation products
    logic [AW-1:0] prod_q_next;
    logic [AW-1:0] prod_t_next;
    logic [AW-1:0] amt_p_next;
    logic [AW-1:0] prod_q1_reg;
    logic [AW-1:0] prod_t1_reg;
    logic [AW-1:0] amt_p1_reg;
    logic          gray1_reg;
    logic [2:0]    sector1_reg;
    logic [VW-1:0] level1_reg;

    // Stage 2: per-channel amounts
    logic [AW-1:0] amt_q;
    logic [AW-1:0] amt_t;
    logic [AW-1:0] amt_r_next;
    logic [AW-1:0] amt_g_next;
    logic [AW-1:0] amt_b_next;
    logic [AW-1:0] amt_r2_reg;
    logic [AW-1:0] amt_g2_reg;
    logic [AW-1:0] amt_b2_reg;
    logic [VW-1:0] level2_reg;

    hsvrgb_en_t  scale_en;
    logic [7:0]  red_ch;
    logic [7:0]  green_ch;
    logic [7:0]  blue_ch;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        stage_en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Carry the in-range flag alongside the data
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ok_reg[0] <= ok_next;
        end
        for (int i = 1; i < NST; i++) begin
            if (stage_en[i]) begin
                ok_reg[i] <= ok_reg[i-1];
            end
        end
    end

    // Decode the incoming color
    always_comb begin
        ok_next   = (32'(s_data.hue) <= FULL_TURN) &&
                    (32'(s_data.saturation) <= LEVEL_ONE) &&
                    (32'(s_data.brightness) <= LEVEL_ONE);
        gray_next = (s_data.saturation == 16'd0);
        hue_w     = (32'(s_data.hue) == FULL_TURN) ? 32'd0 : 32'(s_data.hue);
        sector_next = SEC_RED;
        for (int k = 1; k < 6; k++) begin
            if (hue_w >= 32'(k) * SECTOR_SPAN) begin
                sector_next = sector_next + 3'd1;
            end
        end
        base     = 32'(sector_next) * SECTOR_SPAN;
        rem_next = RW'(hue_w - base);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            gray0_reg   <= gray_next;
            sector0_reg <= sector_next;
            rem0_reg    <= rem_next;
            sat0_reg    <= s_data.saturation;
            level0_reg  <= VW'(s_data.brightness);
        end
    end

    // Form the saturation products
    always_comb begin
        prod_q_next = AW'(sat0_reg) * AW'(rem0_reg);
        prod_t_next = AW'(sat0_reg) * AW'(SPAN_R - rem0_reg);
        amt_p_next  = (ONE_A - AW'(sat0_reg)) * SPAN_A;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_q1_reg <= prod_q_next;
            prod_t1_reg <= prod_t_next;
            amt_p1_reg  <= amt_p_next;
            gray1_reg   <= gray0_reg;
            sector1_reg <= sector0_reg;
            level1_reg  <= level0_reg;
        end
    end

    // Pick v, p, q or t per channel; zero the amounts of a rejected color
    always_comb begin
        amt_q = FULL_AMT - prod_q1_reg;
        amt_t = FULL_AMT - prod_t1_reg;
        case (sector1_reg)
            SEC_RED: begin
                amt_r_next = FULL_AMT;   amt_g_next = amt_t;      amt_b_next = amt_p1_reg;
            end
            SEC_YELLOW: begin
                amt_r_next = amt_q;      amt_g_next = FULL_AMT;   amt_b_next = amt_p1_reg;
            end
            SEC_GREEN: begin
                amt_r_next = amt_p1_reg; amt_g_next = FULL_AMT;   amt_b_next = amt_t;
            end
            SEC_CYAN: begin
                amt_r_next = amt_p1_reg; amt_g_next = amt_q;      amt_b_next = FULL_AMT;
            end
            SEC_BLUE: begin
                amt_r_next = amt_t;      amt_g_next = amt_p1_reg; amt_b_next = FULL_AMT;
            end
            SEC_MAGENTA: begin
                amt_r_next = FULL_AMT;   amt_g_next = amt_p1_reg; amt_b_next = amt_q;
            end
            default: begin
                amt_r_next = FULL_AMT;   amt_g_next = amt_p1_reg; amt_b_next = amt_q;
            end
        endcase
        if (gray1_reg) begin
            amt_r_next = FULL_AMT;
            amt_g_next = FULL_AMT;
            amt_b_next = FULL_AMT;
        end
        if (!ok_reg[1]) begin
            amt_r_next = '0;
            amt_g_next = '0;
            amt_b_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            amt_r2_reg <= amt_r_next;
            amt_g2_reg <= amt_g_next;
            amt_b2_reg <= amt_b_next;
            level2_reg <= level1_reg;
        end
    end

    // Scale the three channels
    assign scale_en = '{mul_en: stage_en[3], sum_en: stage_en[4], div_en: stage_en[5]};

    hsvrgb_scale #(
        .HUE_FRACTION_BITS   (HUE_FRACTION_BITS),
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_scale_red (
        .aclk    (aclk),
        .en      (scale_en),
        .level   (level2_reg),
        .amount  (amt_r2_reg),
        .channel (red_ch)
    );

    hsvrgb_scale #(
        .HUE_FRACTION_BITS   (HUE_FRACTION_BITS),
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_scale_green (
        .aclk    (aclk),
        .en      (scale_en),
        .level   (level2_reg),
        .amount  (amt_g2_reg),
        .channel (green_ch)
    );

    hsvrgb_scale #(
        .HUE_FRACTION_BITS   (HUE_FRACTION_BITS),
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_scale_blue (
        .aclk    (aclk),
        .en      (scale_en),
        .level   (level2_reg),
        .amount  (amt_b2_reg),
        .channel (blue_ch)
    );

    assign m_valid = vld_reg[NST-1];
    assign m_data  = '{accepted: ok_reg[NST-1], red: red_ch, green: green_ch, blue: blue_ch};

`ifndef SYNTH
    a_reject_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.accepted) |->
            (m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("rejected color carries nonzero channels");

    a_ready_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("input stalled while first stage is empty");

    a_transfer_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transfer missing from first stage");

    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NST-1] && !m_ready) |=> (vld_reg[NST-1] && $stable(ok_reg[NST-1])))
        else $error("stalled result lost or changed in last stage");
`endif

endmodule

@@ sv/hsvrgb_scale.sv @@
module hsvrgb_scale
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS   = 6,
    parameter int LEVEL_FRACTION_BITS = 15
) (
    input  logic                                             aclk,
    input  hsvrgb_en_t                                       en,
    input  logic [LEVEL_FRACTION_BITS:0]                     level,
    input  logic [LEVEL_FRACTION_BITS+HUE_FRACTION_BITS+5:0] amount,
    output logic [7:0]                                       channel
);

    localparam int AW = LEVEL_FRACTION_BITS + HUE_FRACTION_BITS + 6;
    localparam int VW = LEVEL_FRACTION_BITS + 1;
    localparam int XW = AW + VW;
    localparam int K  = 2 * LEVEL_FRACTION_BITS + HUE_FRACTION_BITS;
    localparam int YW = XW + 9;
    localparam int QW = SCALED_W + DIV15_W;

    logic [XW-1:0]       prod_reg;
    logic [XW-1:0]       prod_next;
    logic [YW-1:0]       times510;
    logic [15:0]         rounded;
    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic [QW-1:0]       quot;
    logic [7:0]          channel_reg;
    logic [7:0]          channel_next;

    // Multiply brightness by the channel amount
    assign prod_next = XW'(level) * XW'(amount);

    // Times 510, drop the exact fraction bits, add the half and divide by 8
    always_comb begin
        times510    = (YW'(prod_reg) << 9) - (YW'(prod_reg) << 1);
        rounded     = 16'(times510 >> K) + 16'd60;
        scaled_next = SCALED_W'(rounded >> 3);
    end

    // Finish the divide by 15 with a reciprocal multiply
    always_comb begin
        quot         = QW'(scaled_reg) * QW'(DIV15_MUL);
        channel_next = 8'(quot >> DIV15_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (en.mul_en) begin
            prod_reg <= prod_next;
        end
        if (en.sum_en) begin
            scaled_reg <= scaled_next;
        end
        if (en.div_en) begin
            channel_reg <= channel_next;
        end
    end

    assign channel = channel_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench
    import hsvrgb_pkg::*;
();

    localparam int HUE_FB   = 6;
    localparam int LEVEL_FB = 15;

    localparam longint unsigned LEVEL_ONE   = 64'd1 << LEVEL_FB;
    localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FB;
    localparam longint unsigned FULL_TURN   = 64'd360 << HUE_FB;

    localparam int RESET_CYCLES   = 7;
    localparam int MAX_GAP        = 19;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hsv_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rgb_out_t m_data;

    // colors in flight, oldest first
    rgb_out_t expected_rgb[$];
    hsv_in_t  sent_hsv[$];
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;

    hsv_to_rgb #(
        .HUE_FRACTION_BITS   (HUE_FB),
        .LEVEL_FRACTION_BITS (LEVEL_FB)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // level * weight * 255 / (one * one * span), rounded half up
    function automatic logic [7:0] scale_level(input longint unsigned v,
                                               input longint unsigned weight);
        longint unsigned den;
        longint unsigned val;
        den = LEVEL_ONE * LEVEL_ONE * SECTOR_SPAN;
        val = (64'd510 * v * weight + den) / (64'd2 * den);
        if (val > 64'd255)
            val = 64'd255;
        return val[7:0];
    endfunction

    function automatic rgb_out_t convert_hsv(input hsv_in_t c);
        longint unsigned h, s, v, w_v, w_p, w_q, w_t, rem;
        longint unsigned wr, wg, wb;
        int sector;
        rgb_out_t o;
        o = '0;
        h = 64'(c.hue);
        s = 64'(c.saturation);
        v = 64'(c.brightness);
        // out-of-range colors are rejected with all channels dark
        if (h > FULL_TURN || s > LEVEL_ONE || v > LEVEL_ONE)
            return o;
        w_v = LEVEL_ONE * SECTOR_SPAN;
        if (s == 0) begin
            wr = w_v;
            wg = w_v;
            wb = w_v;
        end else begin
            // a full turn is the same as hue zero
            if (h == FULL_TURN)
                h = 0;
            sector = int'(h / SECTOR_SPAN);
            rem    = h % SECTOR_SPAN;
            w_p    = (LEVEL_ONE - s) * SECTOR_SPAN;
            w_q    = w_v - s * rem;
            w_t    = w_v - s * (SECTOR_SPAN - rem);
            case (sector)
                0: begin wr = w_v; wg = w_t; wb = w_p; end
                1: begin wr = w_q; wg = w_v; wb = w_p; end
                2: begin wr = w_p; wg = w_v; wb = w_t; end
                3: begin wr = w_p; wg = w_q; wb = w_v; end
                4: begin wr = w_t; wg = w_p; wb = w_v; end
                default: begin wr = w_v; wg = w_p; wb = w_q; end
            endcase
        end
        o.accepted = 1'b1;
        o.red      = scale_level(v, wr);
        o.green    = scale_level(v, wg);
        o.blue     = scale_level(v, wb);
        return o;
    endfunction

    function automatic hsv_in_t hsv(input int h, input int s, input int v);
        hsv_in_t c;
        c.hue        = h[15:0];
        c.saturation = s[15:0];
        c.brightness = v[15:0];
        return c;
    endfunction

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input hsv_in_t src);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d (h=%0d s=%0d v=%0d)",
                name, got, want, src.hue, src.saturation, src.brightness));
    endtask

    // Called at a rising edge; returns at the edge that completes the transfer.
    task automatic send_color(input hsv_in_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_rgb.push_back(convert_hsv(c));
        sent_hsv.push_back(c);
        s_valid <= 1'b1;
        s_data  <= c;
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_rgb.size() != 0)
            @(posedge aclk);
    endtask

    // Random level: mostly in range, with the limits and raw words mixed in
    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'(LEVEL_ONE);
            2: return int'($urandom_range(0, 16'hFFFF));
            default: return int'($urandom_range(0, 32'(LEVEL_ONE)));
        endcase
    endfunction

    function automatic int pick_hue();
        case ($urandom_range(0, 9))
            0: return int'(FULL_TURN);
            1: return int'(SECTOR_SPAN) * int'($urandom_range(0, 5));
            2: return int'($urandom_range(0, 16'hFFFF));
            default: return int'($urandom_range(0, 32'(FULL_TURN)));
        endcase
    endfunction

    task automatic test_directed();
        int span, one, turn;
        span = int'(SECTOR_SPAN);
        one  = int'(LEVEL_ONE);
        turn = int'(FULL_TURN);
        // black, faint gray, full white
        send_color(hsv(0, 0, 0));
        send_color(hsv(0, 0, 1));
        send_color(hsv(turn, 0, one));
        // hue of a full turn at full saturation wraps to red
        send_color(hsv(turn, one, one));
        // rejects: each field just past its limit, then raw maxima
        send_color(hsv(turn + 1, 0, 0));
        send_color(hsv(0, one + 1, one));
        send_color(hsv(0, 0, one + 1));
        send_color(hsv(16'hFFFF, one, one));
        send_color(hsv(0, 16'hFFFF, 0));
        send_color(hsv(0, 0, 16'hFFFF));
        send_color(hsv(16'hFFFF, 16'hFFFF, 16'hFFFF));
        // every sector: middle at full level, last step at minimum saturation
        for (int k = 0; k < 6; k++) begin
            send_color(hsv(k * span + span / 2, one, one));
            send_color(hsv(k * span + span - 1, 1, one));
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            // switch between idling and full-rate stretches
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_color(hsv(pick_hue(), pick_level(), pick_level()));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_pause_then_burst();
        for (int i = 0; i < 15; i++)
            send_color(hsv(pick_hue(), pick_level(), pick_level()));
        // hold the sender until the pipeline has emptied
        s_valid <= 1'b0;
        wait_drained();
        @(posedge aclk);
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++)
            send_color(hsv(pick_hue(), pick_level(), pick_level()));
        no_idle = 1'b0;
    endtask

    // drive reset, run the tests, then drain and report
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(800);
        test_pause_then_burst();
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side: random stall per result, check against the oldest expectation
    initial begin
        int stall;
        rgb_out_t want;
        hsv_in_t src;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (m_valid !== 1'b1);
            if (expected_rgb.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", m_data));
            end else begin
                want = expected_rgb.pop_front();
                src  = sent_hsv.pop_front();
                check_field("accepted", int'(m_data.accepted), int'(want.accepted), src);
                check_field("red", int'(m_data.red), int'(want.red), src);
                check_field("green", int'(m_data.green), int'(want.green), src);
                check_field("blue", int'(m_data.blue), int'(want.blue), src);
            end
            @(posedge aclk);
        end
    end

    // end the run if no transfer happens on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
